@@ design/rteq_pkg.sv @@
// Package for the relative-time event queue.
// Holds the sequencer state type, op codes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package rteq_pkg;

    localparam int DEPTH_DEFAULT     = 32;
    localparam int COST_BITS_DEFAULT = 16;
    localparam int ID_BITS_DEFAULT   = 16;

    localparam int OP_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_PUT,
        ST_POP_HEAD,
        ST_POP_WALK,
        ST_DONE
    } t_state;

endpackage

@@ design/relative_time_event_queue.sv @@
// Relative-time event queue: sorted scheduler queue in one memory, walked by a sequencer.
// Depends on rteq_pkg.
//
//   channel | handshake                    | payload
//   --------+------------------------------+---------------------------------------------
//   in      | i_in_valid / o_in_stall      | i_op, i_wait_cost, i_agent_id
//   out     | o_out_valid / i_out_stall    | o_served_valid, o_served_id, o_served_cost,
//           |                              | o_insert_rejected, o_entries_left, o_head_cost
//
// Clear, no-op, rejected insert, pop of an empty queue and insert into an empty queue go
// straight to the done state. Insert and pop walk the stored entries through the single memory
// read port, one per cycle; insert walks down from the tail, pop walks up from the head.
// Reset (synchronous, active low) empties the queue; memory contents are not cleared.
// The input is stalled while an operation runs; a finished result waits in the result
// registers while the sequencer holds in its last state until the output register frees up.
`timescale 1ns / 1ps

module relative_time_event_queue
    import rteq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int COST_BITS = COST_BITS_DEFAULT,
    parameter int ID_BITS   = ID_BITS_DEFAULT,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_BITS-1:0]   i_op,
    input  logic [COST_BITS-1:0] i_wait_cost,
    input  logic [ID_BITS-1:0]   i_agent_id,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_served_valid,
    output logic [ID_BITS-1:0]   o_served_id,
    output logic [COST_BITS-1:0] o_served_cost,
    output logic                 o_insert_rejected,
    output logic [CNT_W-1:0]     o_entries_left,
    output logic [COST_BITS-1:0] o_head_cost
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = COST_BITS + ID_BITS;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // entry memory: {cost, id}
    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rd_data;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [COST_BITS-1:0] r_head, n_head;
    logic [COST_BITS-1:0] r_new_cost, n_new_cost;
    logic [ID_BITS-1:0]   r_new_id, n_new_id;
    logic                 r_sv, n_sv;
    logic [ID_BITS-1:0]   r_sid, n_sid;
    logic [COST_BITS-1:0] r_scost, n_scost;
    logic                 r_rej, n_rej;

    logic                 r_out_valid, n_out_valid;
    logic                 r_o_sv, n_o_sv;
    logic [ID_BITS-1:0]   r_o_sid, n_o_sid;
    logic [COST_BITS-1:0] r_o_scost, n_o_scost;
    logic                 r_o_rej, n_o_rej;
    logic [CNT_W-1:0]     r_o_cnt, n_o_cnt;
    logic [COST_BITS-1:0] r_o_head, n_o_head;

    logic                 in_fire;
    logic [COST_BITS-1:0] rd_cost;
    logic [ID_BITS-1:0]   rd_id;
    logic [COST_BITS-1:0] diff;
    logic [CNT_W-1:0]     last_idx;

    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign rd_cost  = r_rd_data[ENT_W-1:ID_BITS];
    assign rd_id    = r_rd_data[ID_BITS-1:0];
    assign diff     = rd_cost - r_scost;
    assign last_idx = r_count - CNT_W'(1);

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_head     <= n_head;
        r_new_cost <= n_new_cost;
        r_new_id   <= n_new_id;
        r_sv       <= n_sv;
        r_sid      <= n_sid;
        r_scost    <= n_scost;
        r_rej      <= n_rej;
        r_o_sv     <= n_o_sv;
        r_o_sid    <= n_o_sid;
        r_o_scost  <= n_o_scost;
        r_o_rej    <= n_o_rej;
        r_o_cnt    <= n_o_cnt;
        r_o_head   <= n_o_head;
    end

    // sequencer: next state, memory control, result capture
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_head      = r_head;
        n_new_cost  = r_new_cost;
        n_new_id    = r_new_id;
        n_sv        = r_sv;
        n_sid       = r_sid;
        n_scost     = r_scost;
        n_rej       = r_rej;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_sv      = r_o_sv;
        n_o_sid     = r_o_sid;
        n_o_scost   = r_o_scost;
        n_o_rej     = r_o_rej;
        n_o_cnt     = r_o_cnt;
        n_o_head    = r_o_head;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = {r_new_cost, r_new_id};
        mem_raddr   = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_sv       = 1'b0;
                    n_sid      = '0;
                    n_scost    = '0;
                    n_rej      = 1'b0;
                    n_new_cost = i_wait_cost;
                    n_new_id   = i_agent_id;
                    n_state    = ST_DONE;
                    case (t_op'(i_op))
                        OP_INSERT: begin
                            if (r_count == FULL_CNT) begin
                                n_rej = 1'b1;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = {i_wait_cost, i_agent_id};
                                n_count   = CNT_W'(1);
                                n_head    = i_wait_cost;
                            end else begin
                                // walk down from the tail
                                mem_raddr = last_idx[IDX_W-1:0];
                                n_idx     = last_idx[IDX_W-1:0];
                                n_state   = ST_INS_WALK;
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                mem_raddr = '0;
                                n_state   = ST_POP_HEAD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_INS_WALK: begin
                if (rd_cost > r_new_cost) begin
                    // shift this entry up one slot
                    mem_we    = 1'b1;
                    mem_waddr = r_idx + IDX_W'(1);
                    mem_wdata = r_rd_data;
                    if (r_idx == '0) begin
                        n_state = ST_INS_PUT;
                    end else begin
                        mem_raddr = r_idx - IDX_W'(1);
                        n_idx     = r_idx - IDX_W'(1);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx + IDX_W'(1);
                    n_count   = r_count + CNT_W'(1);
                    n_state   = ST_DONE;
                end
            end

            ST_INS_PUT: begin
                // new entry becomes the head
                mem_we    = 1'b1;
                mem_waddr = '0;
                n_head    = r_new_cost;
                n_count   = r_count + CNT_W'(1);
                n_state   = ST_DONE;
            end

            ST_POP_HEAD: begin
                n_sv    = 1'b1;
                n_sid   = rd_id;
                n_scost = rd_cost;
                if (r_count == CNT_W'(1)) begin
                    n_count = '0;
                    n_state = ST_DONE;
                end else begin
                    mem_raddr = IDX_W'(1);
                    n_idx     = IDX_W'(1);
                    n_state   = ST_POP_WALK;
                end
            end

            ST_POP_WALK: begin
                // move entry down one slot, rebased by the popped cost
                mem_we    = 1'b1;
                mem_waddr = r_idx - IDX_W'(1);
                mem_wdata = {diff, rd_id};
                if (r_idx == IDX_W'(1)) begin
                    n_head = diff;
                end
                if (CNT_W'(r_idx) == last_idx) begin
                    n_count = last_idx;
                    n_state = ST_DONE;
                end else begin
                    mem_raddr = r_idx + IDX_W'(1);
                    n_idx     = r_idx + IDX_W'(1);
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_sv      = r_sv;
                    n_o_sid     = r_sid;
                    n_o_scost   = r_scost;
                    n_o_rej     = r_rej;
                    n_o_cnt     = r_count;
                    n_o_head    = (r_count == '0) ? '0 : r_head;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_served_valid    = r_o_sv;
    assign o_served_id       = r_o_sid;
    assign o_served_cost     = r_o_scost;
    assign o_insert_rejected = r_o_rej;
    assign o_entries_left    = r_o_cnt;
    assign o_head_cost       = r_o_head;

endmodule
